// ----- rtl/json_string_unescape_unit_assert.svh -----
// Assertion macros for the checker file of this block.
`ifndef JSON_STRING_UNESCAPE_UNIT_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("jsu assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("jsu assertion failed in the following cycle");

`endif

// ----- rtl/jsu_pkg.sv -----
package jsu_pkg;

    localparam int MAX_RES = 5;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [3:0] error_code;
        logic       last;
    } t_out;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_NO_QUOTE  = 4'd1;
    localparam logic [3:0] ERR_CONTROL   = 4'd2;
    localparam logic [3:0] ERR_ESCAPE    = 4'd3;
    localparam logic [3:0] ERR_HEX       = 4'd4;
    localparam logic [3:0] ERR_SURROGATE = 4'd5;
    localparam logic [3:0] ERR_LEAD      = 4'd6;
    localparam logic [3:0] ERR_CONT      = 4'd7;
    localparam logic [3:0] ERR_RANGE     = 4'd8;
    localparam logic [3:0] ERR_TRUNCATED = 4'd9;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [15:0] HIGH_MIN = 16'hd800;
    localparam logic [15:0] HIGH_MAX = 16'hdbff;
    localparam logic [15:0] LOW_MIN  = 16'hdc00;
    localparam logic [15:0] LOW_MAX  = 16'hdfff;
    localparam logic [20:0] CP_MAX   = 21'h10ffff;
    localparam logic [20:0] CP_SUPP  = 21'h010000;

    typedef struct packed {
        logic [2:0]      num;
        logic [3:0][7:0] b;
    } t_enc;

    function automatic t_out mk_res(logic [1:0] kind, logic [7:0] data, logic [3:0] err);
        t_out r;
        r.kind       = kind;
        r.data_byte  = data;
        r.error_code = err;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic t_enc utf8_encode(logic [20:0] cp);
        t_enc e;
        e.b = '0;
        if (cp < 21'h80) begin
            e.num  = 3'd1;
            e.b[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            e.num  = 3'd2;
            e.b[0] = {3'b110, cp[10:6]};
            e.b[1] = {2'b10, cp[5:0]};
        end else if (cp < CP_SUPP) begin
            e.num  = 3'd3;
            e.b[0] = {4'b1110, cp[15:12]};
            e.b[1] = {2'b10, cp[11:6]};
            e.b[2] = {2'b10, cp[5:0]};
        end else begin
            e.num  = 3'd4;
            e.b[0] = {5'b11110, cp[20:18]};
            e.b[1] = {2'b10, cp[17:12]};
            e.b[2] = {2'b10, cp[11:6]};
            e.b[3] = {2'b10, cp[5:0]};
        end
        return e;
    endfunction

    // Returns a valid flag above the four bit digit value.
    function automatic logic [4:0] hex_value(logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'b0;
    endfunction

endpackage

// ----- rtl/json_string_unescape_unit.sv -----
// A byte's first result is registered and offered in the cycle after its acceptance.
// Throughput: one byte per cycle while each byte gives at most one result and the receiver
// keeps up; a byte that gives more than one result blocks the next byte while the result
// register drains one per beat, and a stalled receiver adds its stalls.
// Reset: synchronous and active low; the decoder returns to idle awaiting an opening
// quote and the result register empties.
module json_string_unescape_unit
    import jsu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    typedef enum logic [7:0] {
        M_IDLE    = 8'b0000_0001,
        M_BODY    = 8'b0000_0010,
        M_ESC     = 8'b0000_0100,
        M_HEX     = 8'b0000_1000,
        M_WANT_BS = 8'b0001_0000,
        M_WANT_U  = 8'b0010_0000,
        M_LOW_HEX = 8'b0100_0000,
        M_CONT    = 8'b1000_0000
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [20:0] r_cp, n_cp;
    logic [2:0]  r_dl, n_dl;
    logic [9:0]  r_hh, n_hh;
    logic [2:0]  r_sl, n_sl;

    t_out             r_grp [MAX_RES];
    t_out             n_grp [MAX_RES];
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic             acc, take;
    logic [7:0]       b;
    logic [4:0]       hv;
    logic [15:0]      hcp;
    logic [20:0]      ccp, lo, emit_cp;
    logic [2:0]       ndl;
    logic             s_enc, go_idle, add9;
    logic [2:0]       s_num;
    t_out             s_one;
    t_enc             enc;
    logic [2:0]       idx;

    assign b    = i_data.in_byte;
    assign hv   = hex_value(b);
    assign hcp  = {r_cp[11:0], hv[3:0]};
    assign ccp  = {r_cp[14:0], b[5:0]};
    assign ndl  = r_dl - 3'd1;
    assign lo   = (r_sl == 3'd2) ? 21'h80 : (r_sl == 3'd3) ? 21'h800 : CP_SUPP;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_grp[0];
    assign o_stall = (r_cnt > CNT_W'(1)) || ((r_cnt == CNT_W'(1)) && i_stall);
    assign acc     = i_valid && !o_stall;
    assign take    = o_valid && !i_stall;

    always_comb begin
        n_mode  = r_mode;
        n_cp    = r_cp;
        n_dl    = r_dl;
        n_hh    = r_hh;
        n_sl    = r_sl;
        s_num   = 3'd0;
        s_enc   = 1'b0;
        s_one   = mk_res(KIND_BYTE, 8'h00, ERR_NONE);
        emit_cp = '0;
        go_idle = 1'b0;
        unique case (r_mode)
            M_IDLE: begin
                if (b == CH_QUOTE) begin
                    n_cp   = '0;
                    n_dl   = '0;
                    n_hh   = '0;
                    n_sl   = '0;
                    n_mode = M_BODY;
                end else begin
                    s_one   = mk_res(KIND_ERROR, 8'h00, ERR_NO_QUOTE);
                    s_num   = 3'd1;
                    go_idle = 1'b1;
                end
            end
            M_BODY: begin
                if (b == CH_QUOTE) begin
                    s_one   = mk_res(KIND_END, 8'h00, ERR_NONE);
                    s_num   = 3'd1;
                    go_idle = 1'b1;
                end else if (b == CH_BSLASH) begin
                    n_mode = M_ESC;
                end else if (b < CH_SPACE) begin
                    s_one   = mk_res(KIND_ERROR, 8'h00, ERR_CONTROL);
                    s_num   = 3'd1;
                    go_idle = 1'b1;
                end else if (b < 8'h80) begin
                    s_one = mk_res(KIND_BYTE, b, ERR_NONE);
                    s_num = 3'd1;
                end else if (b >= 8'hc2 && b <= 8'hdf) begin
                    n_sl   = 3'd2;
                    n_dl   = 3'd1;
                    n_cp   = {16'b0, b[4:0]};
                    n_mode = M_CONT;
                end else if (b >= 8'he0 && b <= 8'hef) begin
                    n_sl   = 3'd3;
                    n_dl   = 3'd2;
                    n_cp   = {17'b0, b[3:0]};
                    n_mode = M_CONT;
                end else if (b >= 8'hf0 && b <= 8'hf4) begin
                    n_sl   = 3'd4;
                    n_dl   = 3'd3;
                    n_cp   = {18'b0, b[2:0]};
                    n_mode = M_CONT;
                end else begin
                    s_one   = mk_res(KIND_ERROR, 8'h00, ERR_LEAD);
                    s_num   = 3'd1;
                    go_idle = 1'b1;
                end
            end
            M_CONT: begin
                if (b[7:6] != 2'b10) begin
                    s_one   = mk_res(KIND_ERROR, 8'h00, ERR_CONT);
                    s_num   = 3'd1;
                    go_idle = 1'b1;
                end else if (ndl != 3'd0) begin
                    n_cp = ccp;
                    n_dl = ndl;
                end else if (ccp < lo || ccp > CP_MAX ||
                             (ccp >= {5'b0, HIGH_MIN} && ccp <= {5'b0, LOW_MAX})) begin
                    s_one   = mk_res(KIND_ERROR, 8'h00, ERR_RANGE);
                    s_num   = 3'd1;
                    go_idle = 1'b1;
                end else begin
                    emit_cp = ccp;
                    s_enc   = 1'b1;
                    n_dl    = ndl;
                    n_cp    = '0;
                    n_sl    = '0;
                    n_mode  = M_BODY;
                end
            end
            M_ESC: begin
                n_mode = M_BODY;
                s_num  = 3'd1;
                unique case (b)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: s_one = mk_res(KIND_BYTE, b, ERR_NONE);
                    CH_B: s_one = mk_res(KIND_BYTE, 8'h08, ERR_NONE);
                    CH_F: s_one = mk_res(KIND_BYTE, 8'h0c, ERR_NONE);
                    CH_N: s_one = mk_res(KIND_BYTE, 8'h0a, ERR_NONE);
                    CH_R: s_one = mk_res(KIND_BYTE, 8'h0d, ERR_NONE);
                    CH_T: s_one = mk_res(KIND_BYTE, 8'h09, ERR_NONE);
                    CH_U: begin
                        s_num  = 3'd0;
                        n_mode = M_HEX;
                        n_dl   = 3'd4;
                        n_cp   = '0;
                    end
                    default: begin
                        s_one   = mk_res(KIND_ERROR, 8'h00, ERR_ESCAPE);
                        go_idle = 1'b1;
                    end
                endcase
            end
            M_HEX, M_LOW_HEX: begin
                if (!hv[4]) begin
                    s_one   = mk_res(KIND_ERROR, 8'h00, ERR_HEX);
                    s_num   = 3'd1;
                    go_idle = 1'b1;
                end else if (ndl != 3'd0) begin
                    n_cp = {5'b0, hcp};
                    n_dl = ndl;
                end else begin
                    n_cp = '0;
                    n_dl = ndl;
                    if (r_mode == M_HEX) begin
                        if (hcp >= HIGH_MIN && hcp <= HIGH_MAX) begin
                            n_hh   = hcp[9:0];
                            n_mode = M_WANT_BS;
                        end else if (hcp >= LOW_MIN && hcp <= LOW_MAX) begin
                            s_one   = mk_res(KIND_ERROR, 8'h00, ERR_SURROGATE);
                            s_num   = 3'd1;
                            go_idle = 1'b1;
                        end else begin
                            emit_cp = {5'b0, hcp};
                            s_enc   = 1'b1;
                            n_mode  = M_BODY;
                        end
                    end else if (hcp < LOW_MIN || hcp > LOW_MAX) begin
                        s_one   = mk_res(KIND_ERROR, 8'h00, ERR_SURROGATE);
                        s_num   = 3'd1;
                        go_idle = 1'b1;
                    end else begin
                        emit_cp = CP_SUPP + {1'b0, r_hh, hcp[9:0]};
                        s_enc   = 1'b1;
                        n_hh    = '0;
                        n_mode  = M_BODY;
                    end
                end
            end
            M_WANT_BS: begin
                if (b == CH_BSLASH) begin
                    n_mode = M_WANT_U;
                end else begin
                    s_one   = mk_res(KIND_ERROR, 8'h00, ERR_SURROGATE);
                    s_num   = 3'd1;
                    go_idle = 1'b1;
                end
            end
            M_WANT_U: begin
                if (b == CH_U) begin
                    n_mode = M_LOW_HEX;
                    n_dl   = 3'd4;
                    n_cp   = '0;
                end else begin
                    s_one   = mk_res(KIND_ERROR, 8'h00, ERR_SURROGATE);
                    s_num   = 3'd1;
                    go_idle = 1'b1;
                end
            end
            default: go_idle = 1'b1;
        endcase
        enc = utf8_encode(emit_cp);
        if (s_enc) begin
            s_num = enc.num;
        end
        if (go_idle) begin
            n_mode = M_IDLE;
            n_cp   = '0;
            n_dl   = '0;
            n_hh   = '0;
            n_sl   = '0;
        end
        add9 = i_data.end_of_text && (n_mode != M_IDLE);
        if (add9) begin
            n_mode = M_IDLE;
            n_cp   = '0;
            n_dl   = '0;
            n_hh   = '0;
            n_sl   = '0;
        end
        n_cnt = CNT_W'(s_num) + CNT_W'(add9);
    end

    always_comb begin
        idx = 3'd0;
        for (int i = 0; i < MAX_RES; i++) begin
            idx = 3'(i);
            if (idx < s_num) begin
                n_grp[i] = s_enc ? mk_res(KIND_BYTE, enc.b[idx[1:0]], ERR_NONE) : s_one;
            end else if (idx == s_num && add9) begin
                n_grp[i] = mk_res(KIND_ERROR, 8'h00, ERR_TRUNCATED);
            end else begin
                n_grp[i] = mk_res(KIND_BYTE, 8'h00, ERR_NONE);
            end
            n_grp[i].last = (CNT_W'(idx) + CNT_W'(1) == n_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_cp   <= '0;
            r_dl   <= '0;
            r_hh   <= '0;
            r_sl   <= '0;
            r_cnt  <= '0;
        end else if (acc) begin
            r_mode <= n_mode;
            r_cp   <= n_cp;
            r_dl   <= n_dl;
            r_hh   <= n_hh;
            r_sl   <= n_sl;
            r_cnt  <= n_cnt;
        end else if (take) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_grp <= n_grp;
        end else if (take) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                r_grp[i] <= r_grp[i + 1];
            end
        end
    end

endmodule

// ----- rtl/jsu_checker.sv -----
`include "json_string_unescape_unit_assert.svh"

module jsu_checker
    import jsu_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input t_in  i_data,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);

    // The input side only waits while results are still pending.
    `JSU_ASSERT_SAME(a_stall_needs_pending, i_clk, i_rst_n, o_stall, o_valid)

    // An end marker or an error always closes the results of its byte.
    `JSU_ASSERT_SAME(a_marker_is_last, i_clk, i_rst_n,
        o_valid && (o_data.kind != KIND_BYTE), o_data.last)

    // An error code appears exactly on error beats.
    `JSU_ASSERT_SAME(a_code_on_error, i_clk, i_rst_n, o_valid,
        (o_data.kind == KIND_ERROR) == (o_data.error_code != ERR_NONE))

    // A stalled result beat holds its payload.
    `JSU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_data))

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (.*);

// ----- sim/json_string_unescape_unit_tb.sv -----
`timescale 1ns / 100ps

module json_string_unescape_unit_tb;
    import jsu_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 10;
    localparam int MAX_SHOWN    = 10;
    localparam int RANDOM_BEATS = 120;

    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_TAB = 8'h09;
    localparam logic [7:0] CTL_LF  = 8'h0a;
    localparam logic [7:0] CTL_FF  = 8'h0c;
    localparam logic [7:0] CTL_CR  = 8'h0d;

    localparam logic [7:0] ESC_LETTERS [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                               CH_F, CH_N, CH_R, CH_T};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BODY,
        ST_ESC,
        ST_HEX,
        ST_WANT_BS,
        ST_WANT_U,
        ST_LOW_HEX,
        ST_CONT
    } t_dec_state;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in  i_data  = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_data;

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int beats_sent     = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    t_out       decoded_q[$];
    t_out       beat_res[$];
    logic [7:0] text_q[$];

    t_dec_state  dec_state;
    logic [20:0] acc_cp;
    logic [2:0]  acc_left;
    logic [9:0]  hi_half;
    logic [2:0]  seq_len;

    json_string_unescape_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic void report_beat(string what, t_out want, t_out got);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) begin
            $display("%s at cycle %0d: expected kind %0d byte %02h code %0d last %0d",
                     what, cycle_count, want.kind, want.data_byte, want.error_code, want.last);
            $display("    got kind %0d byte %02h code %0d last %0d",
                     got.kind, got.data_byte, got.error_code, got.last);
        end
    endfunction

    function automatic void check_result(t_out got);
        t_out want;
        if (decoded_q.size() == 0) begin
            report_beat("unexpected result", '0, got);
            return;
        end
        want = decoded_q.pop_front();
        if (got.kind !== want.kind || got.data_byte !== want.data_byte
                || got.error_code !== want.error_code || got.last !== want.last) begin
            report_beat("mismatch", want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            check_result(o_data);
        end
    end

    function automatic int utf8_len(logic [20:0] cp);
        if (cp < 21'h80) return 1;
        if (cp < 21'h800) return 2;
        if (cp < CP_SUPP) return 3;
        return 4;
    endfunction

    // The first byte of the encoding sits in the top lane.
    function automatic logic [31:0] utf8_bytes(logic [20:0] cp);
        case (utf8_len(cp))
            1: return {cp[7:0], 24'h0};
            2: return {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
            3: return {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
            default: return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                             2'b10, cp[5:0]};
        endcase
    endfunction

    function automatic int nibble_of(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    function automatic void clear_decoder();
        dec_state = ST_IDLE;
        acc_cp    = '0;
        acc_left  = '0;
        hi_half   = '0;
        seq_len   = '0;
    endfunction

    function automatic void add_result(logic [1:0] kind, logic [7:0] data, logic [3:0] err);
        t_out r;
        r.kind       = kind;
        r.data_byte  = data;
        r.error_code = err;
        r.last       = 1'b0;
        if (beat_res.size() < MAX_RES) beat_res.insert(beat_res.size(), r);
    endfunction

    function automatic void abort(logic [3:0] err);
        add_result(KIND_ERROR, 8'h00, err);
        clear_decoder();
    endfunction

    function automatic void add_code_point(logic [20:0] cp);
        logic [31:0] enc;
        enc = utf8_bytes(cp);
        for (int i = 0; i < utf8_len(cp); i++) add_result(KIND_BYTE, enc[31 - 8*i -: 8], ERR_NONE);
    endfunction

    function automatic void decode_body(logic [7:0] b);
        logic [2:0] n;
        if (b == CH_QUOTE) begin
            add_result(KIND_END, 8'h00, ERR_NONE);
            clear_decoder();
        end else if (b == CH_BSLASH) begin
            dec_state = ST_ESC;
        end else if (b < CH_SPACE) begin
            abort(ERR_CONTROL);
        end else if (b < 8'h80) begin
            add_result(KIND_BYTE, b, ERR_NONE);
        end else if (b < 8'hc2 || b > 8'hf4) begin
            abort(ERR_LEAD);
        end else begin
            n = (b <= 8'hdf) ? 3'd2 : (b <= 8'hef) ? 3'd3 : 3'd4;
            seq_len  = n;
            acc_left = n - 3'd1;
            acc_cp   = (n == 3'd2) ? {16'd0, b[4:0]} :
                       (n == 3'd3) ? {17'd0, b[3:0]} : {18'd0, b[2:0]};
            dec_state = ST_CONT;
        end
    endfunction

    function automatic void decode_cont(logic [7:0] b);
        logic [20:0] floor_cp;
        if (b[7:6] != 2'b10) begin
            abort(ERR_CONT);
            return;
        end
        acc_cp   = {acc_cp[14:0], b[5:0]};
        acc_left = acc_left - 3'd1;
        if (acc_left != 3'd0) return;
        floor_cp = (seq_len == 3'd2) ? 21'h80 : (seq_len == 3'd3) ? 21'h800 : CP_SUPP;
        if (acc_cp < floor_cp || acc_cp > CP_MAX
                || (acc_cp >= HIGH_MIN && acc_cp <= LOW_MAX)) begin
            abort(ERR_RANGE);
        end else begin
            add_code_point(acc_cp);
            acc_cp    = '0;
            seq_len   = '0;
            dec_state = ST_BODY;
        end
    endfunction

    function automatic void decode_escape(logic [7:0] b);
        dec_state = ST_BODY;
        case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: add_result(KIND_BYTE, b, ERR_NONE);
            CH_B: add_result(KIND_BYTE, CTL_BS, ERR_NONE);
            CH_F: add_result(KIND_BYTE, CTL_FF, ERR_NONE);
            CH_N: add_result(KIND_BYTE, CTL_LF, ERR_NONE);
            CH_R: add_result(KIND_BYTE, CTL_CR, ERR_NONE);
            CH_T: add_result(KIND_BYTE, CTL_TAB, ERR_NONE);
            CH_U: begin
                dec_state = ST_HEX;
                acc_left  = 3'd4;
                acc_cp    = '0;
            end
            default: abort(ERR_ESCAPE);
        endcase
    endfunction

    function automatic void decode_hex(logic [7:0] b, logic low);
        int          nib;
        logic [15:0] unit;
        nib = nibble_of(b);
        if (nib < 0) begin
            abort(ERR_HEX);
            return;
        end
        acc_cp   = {5'd0, acc_cp[11:0], nib[3:0]};
        acc_left = acc_left - 3'd1;
        if (acc_left != 3'd0) return;
        unit   = acc_cp[15:0];
        acc_cp = '0;
        if (!low) begin
            if (unit >= HIGH_MIN && unit <= HIGH_MAX) begin
                hi_half   = unit[9:0];
                dec_state = ST_WANT_BS;
            end else if (unit >= LOW_MIN && unit <= LOW_MAX) begin
                abort(ERR_SURROGATE);
            end else begin
                add_code_point({5'd0, unit});
                dec_state = ST_BODY;
            end
        end else if (unit < LOW_MIN || unit > LOW_MAX) begin
            abort(ERR_SURROGATE);
        end else begin
            add_code_point(CP_SUPP + {1'b0, hi_half, unit[9:0]});
            hi_half   = '0;
            dec_state = ST_BODY;
        end
    endfunction

    function automatic void decode_beat(t_in beat);
        logic [7:0] b;
        t_out       tail;
        b = beat.in_byte;
        beat_res = {};
        case (dec_state)
            ST_IDLE: begin
                if (b == CH_QUOTE) begin
                    clear_decoder();
                    dec_state = ST_BODY;
                end else begin
                    abort(ERR_NO_QUOTE);
                end
            end
            ST_BODY: decode_body(b);
            ST_ESC: decode_escape(b);
            ST_HEX: decode_hex(b, 1'b0);
            ST_WANT_BS: begin
                if (b == CH_BSLASH) dec_state = ST_WANT_U;
                else abort(ERR_SURROGATE);
            end
            ST_WANT_U: begin
                if (b == CH_U) begin
                    dec_state = ST_LOW_HEX;
                    acc_left  = 3'd4;
                    acc_cp    = '0;
                end else begin
                    abort(ERR_SURROGATE);
                end
            end
            ST_LOW_HEX: decode_hex(b, 1'b1);
            ST_CONT: decode_cont(b);
            default: clear_decoder();
        endcase
        if (beat.end_of_text && dec_state != ST_IDLE) abort(ERR_TRUNCATED);
        if (beat_res.size() > 0) begin
            tail = beat_res[beat_res.size() - 1];
            tail.last = 1'b1;
            beat_res[beat_res.size() - 1] = tail;
        end
        foreach (beat_res[i]) decoded_q.insert(decoded_q.size(), beat_res[i]);
    endfunction

    task automatic send_beat(logic [7:0] b, logic eot);
        t_in beat;
        beat.in_byte     = b;
        beat.end_of_text = eot;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        do @(posedge i_clk); while (o_stall);
        beats_sent++;
        decode_beat(beat);
    endtask

    task automatic send_text(int eot_at);
        int stop;
        stop = (eot_at >= 0) ? eot_at : text_q.size() - 1;
        for (int i = 0; i <= stop; i++) send_beat(text_q[i], i == eot_at);
        text_q = {};
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic void put_byte(logic [7:0] c);
        text_q.insert(text_q.size(), c);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        logic [7:0] base;
        if (nib < 4'd10) return 8'h30 + nib;
        base = $urandom_range(1) ? 8'h41 : 8'h61;
        return base + nib - 8'd10;
    endfunction

    function automatic void put_u_escape(logic [15:0] unit);
        put_byte(CH_BSLASH);
        put_byte(CH_U);
        for (int i = 3; i >= 0; i--) put_byte(hex_char(unit[4*i +: 4]));
    endfunction

    function automatic void put_raw(logic [20:0] cp);
        logic [31:0] enc;
        enc = utf8_bytes(cp);
        for (int i = 0; i < utf8_len(cp); i++) put_byte(enc[31 - 8*i -: 8]);
    endfunction

    function automatic void put_token();
        int          pick;
        logic [7:0]  c;
        logic [20:0] cp;
        pick = $urandom_range(99);
        if (pick < 35) begin
            c = 8'($urandom_range(8'h7f, 8'h20));
            if (c == CH_QUOTE || c == CH_BSLASH) c = CH_SPACE;
            put_byte(c);
        end else if (pick < 50) begin
            put_byte(CH_BSLASH);
            put_byte(ESC_LETTERS[$urandom_range(7)]);
        end else if (pick < 62) begin
            case ($urandom_range(2))
                0: cp = 21'($urandom_range(16'h7f));
                1: cp = 21'($urandom_range(16'h7ff));
                default: cp = 21'($urandom_range(16'hffff));
            endcase
            if (cp >= HIGH_MIN && cp <= LOW_MAX) cp = cp ^ 21'h4000;
            put_u_escape(cp[15:0]);
        end else if (pick < 72) begin
            put_u_escape(HIGH_MIN + 16'($urandom_range(10'h3ff)));
            put_u_escape(LOW_MIN + 16'($urandom_range(10'h3ff)));
        end else begin
            case ($urandom_range(2))
                0: cp = 21'($urandom_range(21'h7ff, 21'h80));
                1: cp = 21'($urandom_range(21'hffff, 21'h800));
                default: cp = 21'($urandom_range(CP_MAX, CP_SUPP));
            endcase
            if (cp >= HIGH_MIN && cp <= LOW_MAX) cp = cp ^ 21'h4000;
            put_raw(cp);
        end
    endfunction

    function automatic void put_fault();
        int         n;
        logic [7:0] c;
        logic [7:0] lead;
        case ($urandom_range(9))
            0: put_byte(8'($urandom_range(8'h1f)));
            1: begin
                c = 8'($urandom_range(255));
                case (c)
                    CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U: c = 8'h78;
                    default: ;
                endcase
                put_byte(CH_BSLASH);
                put_byte(c);
            end
            2: begin
                put_byte(CH_BSLASH);
                put_byte(CH_U);
                repeat ($urandom_range(3)) put_byte(hex_char(4'($urandom_range(15))));
                c = 8'($urandom_range(255));
                if (nibble_of(c) >= 0) c = 8'h67;
                put_byte(c);
            end
            3: put_u_escape(LOW_MIN + 16'($urandom_range(10'h3ff)));
            4: begin
                put_u_escape(HIGH_MIN + 16'($urandom_range(10'h3ff)));
                case ($urandom_range(3))
                    0: begin
                        c = 8'($urandom_range(255));
                        put_byte(c == CH_BSLASH ? 8'h61 : c);
                    end
                    1: begin
                        c = 8'($urandom_range(255));
                        put_byte(CH_BSLASH);
                        put_byte(c == CH_U ? 8'h6e : c);
                    end
                    2: begin
                        c = 8'($urandom_range(255));
                        put_byte(CH_BSLASH);
                        put_byte(CH_U);
                        put_byte(nibble_of(c) >= 0 ? 8'h7a : c);
                    end
                    default: put_u_escape(16'($urandom_range(16'hdbff)));
                endcase
            end
            5: begin
                c = $urandom_range(1) ? 8'($urandom_range(8'hc1, 8'h80))
                                      : 8'($urandom_range(8'hff, 8'hf5));
                put_byte(c);
            end
            6: begin
                lead = 8'($urandom_range(8'hf4, 8'hc2));
                n = (lead <= 8'hdf) ? 1 : (lead <= 8'hef) ? 2 : 3;
                put_byte(lead);
                repeat ($urandom_range(n - 1)) put_byte(8'h80 | 8'($urandom_range(63)));
                c = 8'($urandom_range(255));
                if (c[7:6] == 2'b10) c[6] = 1'b1;
                put_byte(c);
            end
            7: begin
                case ($urandom_range(3))
                    0: begin
                        lead = 8'he0;
                        c = 8'h80 + 8'($urandom_range(8'h1f));
                    end
                    1: begin
                        lead = 8'hed;
                        c = 8'ha0 + 8'($urandom_range(8'h1f));
                    end
                    2: begin
                        lead = 8'hf0;
                        c = 8'h80 + 8'($urandom_range(8'h0f));
                    end
                    default: begin
                        lead = 8'hf4;
                        c = 8'h90 + 8'($urandom_range(8'h2f));
                    end
                endcase
                put_byte(lead);
                put_byte(c);
                repeat (lead >= 8'hf0 ? 2 : 1) put_byte(8'h80 | 8'($urandom_range(63)));
            end
            8: repeat ($urandom_range(4, 1)) put_byte(8'($urandom_range(255)));
            default: begin
                put_byte(CH_BSLASH);
                put_byte(8'($urandom_range(255)));
            end
        endcase
    endfunction

    task automatic send_random_string();
        int eot_at;
        text_q = {};
        if ($urandom_range(9) == 0) put_byte(8'($urandom_range(255)));
        put_byte(CH_QUOTE);
        repeat ($urandom_range(6)) put_token();
        if ($urandom_range(99) < 65) put_byte(CH_QUOTE);
        else put_fault();
        eot_at = -1;
        if ($urandom_range(9) == 0) eot_at = $urandom_range(text_q.size() - 1);
        else if ($urandom_range(9) == 0) eot_at = text_q.size() - 1;
        send_text(eot_at);
    endtask

    task automatic test_idle_bytes();
        send_beat(8'h00, 1'b0);
        send_beat(8'hff, 1'b1);
    endtask

    task automatic test_escapes();
        text_q = {CH_QUOTE};
        foreach (ESC_LETTERS[i]) begin
            put_byte(CH_BSLASH);
            put_byte(ESC_LETTERS[i]);
        end
        put_u_escape(16'h0000);
        put_u_escape(HIGH_MAX);
        put_u_escape(LOW_MAX);
        put_byte(CH_QUOTE);
        send_text(-1);
    endtask

    task automatic test_raw_range();
        text_q = {CH_QUOTE, 8'hf4, 8'h90, 8'h80, 8'h80};
        send_text(-1);
    endtask

    task automatic test_truncation();
        text_q = {CH_QUOTE, 8'he0};
        send_text(1);
    endtask

    task automatic test_random_strings();
        int start;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 15;
                    recv_idle_pct = 57;
                end
                1: begin
                    send_idle_pct = 57;
                    recv_idle_pct = 15;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            start = beats_sent;
            while (beats_sent - start < RANDOM_BEATS / 3) send_random_string();
            // Hold the input until every decoded beat has left the block.
            wait_for_drain();
        end
    endtask

    initial begin
        clear_decoder();
        send_idle_pct = 15;
        recv_idle_pct = 57;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_bytes();
        test_escapes();
        test_raw_range();
        test_truncation();
        test_random_strings();

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (decoded_q.size() != 0) begin
            $display("%0d decoded beats never arrived", decoded_q.size());
            mismatch_count += decoded_q.size();
        end
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
